// ----- rtl/tvm_pkg.sv -----
// ----------------------------------------------------------------------------
// tvm_pkg: shared constants
// Register indexes, width constants and the fraction widths for gain and alpha.
// ----------------------------------------------------------------------------
`default_nettype none
package tvm_pkg;
   localparam int unsigned CsrIdxWidth = 3;
   localparam int unsigned CsrDataWidth = 21;
   localparam logic [CsrIdxWidth-1:0] REG_DEADZONE = 3'd0;
   localparam logic [CsrIdxWidth-1:0] REG_GAIN_EDGE = 3'd1;
   localparam logic [CsrIdxWidth-1:0] REG_GAIN_SLOPE = 3'd2;
   localparam logic [CsrIdxWidth-1:0] REG_MAX_SPEED = 3'd3;
   localparam logic [CsrIdxWidth-1:0] REG_ALPHA = 3'd4;
   localparam logic [CsrIdxWidth-1:0] REG_Z_ENABLE = 3'd5;
   localparam int unsigned GainFrac = 12;
   localparam int unsigned AlphaFrac = 16;
endpackage
`default_nettype wire

// ----- rtl/tvm_front.sv -----
// ----------------------------------------------------------------------------
// tvm_front: offset magnitude and classification
// Mirrors x and y, takes the squared norm and an iterative square root,
// then works out whether the item lies in the deadzone and its gain.
// ----------------------------------------------------------------------------
`default_nettype none
module tvm_front #(
   parameter int unsigned SW = 24,
   parameter int unsigned FB = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   output logic                   in_ready,
   input  wire logic signed [SW-1:0] in_x,
   input  wire logic signed [SW-1:0] in_y,
   input  wire logic signed [SW-1:0] in_z,
   input  wire logic [16:0]       deadzone,
   input  wire logic [15:0]       gain_edge,
   input  wire logic [15:0]       gain_slope,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output logic [SW:0]            out_mx,
   output logic [SW:0]            out_my,
   output logic [SW:0]            out_mz,
   output logic [2:0]             out_neg,
   output logic                   out_live,
   output logic [15:0]            out_gain,
   output logic [SW+1:0]          out_norm
);
   localparam int unsigned MW = SW + 1;
   localparam int unsigned QW = 2 * MW + 2;
   localparam int unsigned NW = MW + 1;
   localparam int unsigned STEPS = QW / 2;
   localparam int unsigned CW = $clog2(STEPS + 4);

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001, S_SQ = 5'b00010, S_ROOT = 5'b00100,
      S_GAIN = 5'b01000, S_DONE = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic [MW-1:0] m_ff [3], m_in [3];
   logic [2:0] neg_ff, neg_in;
   logic [1:0] sq_ix_ff, sq_ix_in;
   logic [QW-1:0] acc_ff, acc_in;
   logic [QW-1:0] rem_ff, rem_in;
   logic [NW-1:0] root_ff, root_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic live_ff, live_in;
   logic [15:0] gain_ff, gain_in;

   logic [QW-1:0] trial;
   logic [QW-1:0] rem_sh;
   logic [2*MW-1:0] sq_term;
   logic [NW:0] excess;
   logic [NW+16:0] prod;
   logic [NW+16:0] gsum;

   always_comb begin
      sq_term = m_ff[sq_ix_ff] * m_ff[sq_ix_ff];
      rem_sh = {rem_ff[QW-3:0], acc_ff[QW-1:QW-2]};
      trial = {root_ff[NW-1:0], 2'b01};
      excess = {1'b0, root_ff} - {{(NW-16){1'b0}}, deadzone};
      prod = excess[NW-1:0] * gain_slope;
      gsum = (prod >> (FB - 4)) + {{(NW+1){1'b0}}, gain_edge};
   end

   always_comb begin
      state_in = state_ff;
      m_in = m_ff;
      neg_in = neg_ff;
      sq_ix_in = sq_ix_ff;
      acc_in = acc_ff;
      rem_in = rem_ff;
      root_in = root_ff;
      cnt_in = cnt_ff;
      live_in = live_ff;
      gain_in = gain_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (in_valid) begin
               // mirrored x/y: sign flips, magnitudes stay
               neg_in = {in_z[SW-1], ~in_y[SW-1] & (in_y != '0),
                         ~in_x[SW-1] & (in_x != '0)};
               m_in[0] = in_x[SW-1] ? MW'(-{in_x[SW-1], in_x}) : MW'(in_x);
               m_in[1] = in_y[SW-1] ? MW'(-{in_y[SW-1], in_y}) : MW'(in_y);
               m_in[2] = in_z[SW-1] ? MW'(-{in_z[SW-1], in_z}) : MW'(in_z);
               acc_in = '0;
               sq_ix_in = '0;
               state_in = S_SQ;
            end
         end
         S_SQ: begin
            acc_in = acc_ff + QW'(sq_term);
            sq_ix_in = sq_ix_ff + 2'd1;
            if (sq_ix_ff == 2'd2) begin
               rem_in = '0;
               root_in = '0;
               cnt_in = '0;
               state_in = S_ROOT;
            end
         end
         S_ROOT: begin
            // restoring square root, two bits a step
            acc_in = {acc_ff[QW-3:0], 2'b00};
            if (rem_sh >= trial) begin
               rem_in = rem_sh - trial;
               root_in = {root_ff[NW-2:0], 1'b1};
            end else begin
               rem_in = rem_sh;
               root_in = {root_ff[NW-2:0], 1'b0};
            end
            cnt_in = cnt_ff + CW'(1);
            if (cnt_ff == CW'(STEPS - 1)) state_in = S_GAIN;
         end
         S_GAIN: begin
            live_in = root_ff > {{(NW-17){1'b0}}, deadzone};
            gain_in = (gsum > (NW+17)'(16'hFFFF)) ? 16'hFFFF : gsum[15:0];
            state_in = S_DONE;
         end
         S_DONE: begin
            if (out_ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
      m_ff <= m_in;
      neg_ff <= neg_in;
      sq_ix_ff <= sq_ix_in;
      acc_ff <= acc_in;
      rem_ff <= rem_in;
      root_ff <= root_in;
      cnt_ff <= cnt_in;
      live_ff <= live_in;
      gain_ff <= gain_in;
   end

   assign in_ready = (state_ff == S_IDLE);
   assign out_valid = (state_ff == S_DONE);
   assign out_mx = m_ff[0];
   assign out_my = m_ff[1];
   assign out_mz = m_ff[2];
   assign out_neg = neg_ff;
   assign out_live = live_ff;
   assign out_gain = gain_ff;
   assign out_norm = root_ff;
endmodule
`default_nettype wire

// ----- rtl/tvm_back.sv -----
// ----------------------------------------------------------------------------
// tvm_back: command, clamp and low-pass filter
// Per axis: zero command, gain scaling or speed clamp through a shared
// serial divider, then the one-pole filter update of the stored velocity.
// ----------------------------------------------------------------------------
`default_nettype none
module tvm_back #(
   parameter int unsigned SW = 24
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   output logic                   in_ready,
   input  wire logic [SW:0]       in_mx,
   input  wire logic [SW:0]       in_my,
   input  wire logic [SW:0]       in_mz,
   input  wire logic [2:0]        in_neg,
   input  wire logic              in_live,
   input  wire logic [15:0]       in_gain,
   input  wire logic [SW+1:0]     in_norm,
   input  wire logic [20:0]       max_speed,
   input  wire logic [15:0]       alpha,
   input  wire logic              z_enable,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output logic signed [SW-1:0]   out_x,
   output logic signed [SW-1:0]   out_y,
   output logic signed [SW-1:0]   out_z
);
   localparam int unsigned MW = SW + 1;
   localparam int unsigned NW = SW + 2;
   localparam int unsigned PW = MW + 21;
   localparam int unsigned DW = SW + 2;
   localparam int unsigned CW = $clog2(PW + 1);
   localparam logic signed [DW-1:0] SMAX = DW'((64'd1 << (SW - 1)) - 64'd1);
   localparam logic signed [DW-1:0] SMIN = -SMAX - DW'(1);

   typedef enum logic [6:0] {
      S_IDLE = 7'b0000001, S_NORM = 7'b0000010, S_CMD = 7'b0000100,
      S_DIV = 7'b0001000, S_DIFF = 7'b0010000, S_FILT = 7'b0100000,
      S_OUT = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic [MW-1:0] m_ff [3], m_in [3];
   logic [2:0] neg_ff, neg_in;
   logic live_ff, live_in;
   logic [15:0] gain_ff, gain_in;
   logic [NW-1:0] norm_ff, norm_in;
   logic clamp_ff, clamp_in;
   logic [1:0] ax_ff, ax_in;
   logic [PW-1:0] quo_ff, quo_in;
   logic [NW:0] rem_ff, rem_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic signed [DW-1:0] cmd_ff, cmd_in;
   logic signed [DW:0] diff_ff, diff_in;
   logic signed [SW-1:0] fv_ff [3], fv_in [3];
   logic [SW-1:0] ox_ff, oy_ff, oz_ff, ox_in, oy_in, oz_in;
   logic out_valid_ff, out_valid_in;

   logic [NW+16:0] cnorm;
   logic [MW+15:0] gprod;
   logic [MW+15:0] gmag;
   logic [DW-1:0] mag_sel;
   logic [NW:0] rem_sh;
   logic [DW:0] dmag;
   logic [DW+16:0] fprod;
   logic [DW:0] fstep;
   logic signed [DW+1:0] fsum;
   logic signed [DW-1:0] cmd_sat;

   function automatic logic signed [DW-1:0] sat_mag(input logic neg,
                                                    input logic [DW-1:0] m);
      logic signed [DW-1:0] r;
      begin
         r = neg ? -$signed(m) : $signed(m);
         if (!neg && m > DW'(SMAX)) r = SMAX;
         if (neg && m > DW'(SMAX) + DW'(1)) r = SMIN;
         sat_mag = r;
      end
   endfunction

   always_comb begin
      cnorm = (norm_ff * gain_ff) >> tvm_pkg::GainFrac;
      gprod = m_ff[ax_ff] * gain_ff;
      gmag = gprod >> tvm_pkg::GainFrac;
      mag_sel = (gmag > (MW+16)'(2 ** DW - 1)) ? {DW{1'b1}} : gmag[DW-1:0];
      rem_sh = {rem_ff[NW-1:0], quo_ff[PW-1]};
      cmd_sat = sat_mag(neg_ff[ax_ff], clamp_ff
         ? ((quo_ff > PW'(2 ** DW - 1)) ? {DW{1'b1}} : quo_ff[DW-1:0])
         : mag_sel);
      dmag = diff_ff[DW] ? DW'(-diff_ff) : DW'(diff_ff);
      fprod = dmag * alpha;
      fstep = (DW+1)'((fprod + (DW+17)'(32768)) >> tvm_pkg::AlphaFrac);
   end

   always_comb begin
      fsum = (DW+2)'(fv_ff[ax_ff]) + (diff_ff[DW] ? -(DW+2)'(fstep) : (DW+2)'(fstep));
   end

   always_comb begin
      state_in = state_ff;
      m_in = m_ff;
      neg_in = neg_ff;
      live_in = live_ff;
      gain_in = gain_ff;
      norm_in = norm_ff;
      clamp_in = clamp_ff;
      ax_in = ax_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      cnt_in = cnt_ff;
      cmd_in = cmd_ff;
      diff_in = diff_ff;
      fv_in = fv_ff;
      ox_in = ox_ff;
      oy_in = oy_ff;
      oz_in = oz_ff;
      out_valid_in = out_valid_ff;
      if (out_valid_ff && out_ready) out_valid_in = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (in_valid) begin
               m_in[0] = in_mx;
               m_in[1] = in_my;
               m_in[2] = in_mz;
               neg_in = in_neg;
               live_in = in_live;
               gain_in = in_gain;
               norm_in = in_norm;
               ax_in = '0;
               state_in = S_NORM;
            end
         end
         S_NORM: begin
            clamp_in = cnorm > (NW+17)'(max_speed);
            state_in = S_CMD;
         end
         S_CMD: begin
            if (!live_ff || (ax_ff == 2'd2 && !z_enable)) begin
               cmd_in = '0;
               state_in = S_DIFF;
            end else if (clamp_ff) begin
               quo_in = m_ff[ax_ff] * max_speed;
               rem_in = '0;
               cnt_in = '0;
               state_in = S_DIV;
            end else begin
               cmd_in = cmd_sat;
               state_in = S_DIFF;
            end
         end
         S_DIV: begin
            // restoring divide by the norm, one quotient bit a cycle
            if (rem_sh >= {1'b0, norm_ff}) begin
               rem_in = rem_sh - {1'b0, norm_ff};
               quo_in = {quo_ff[PW-2:0], 1'b1};
            end else begin
               rem_in = rem_sh;
               quo_in = {quo_ff[PW-2:0], 1'b0};
            end
            cnt_in = cnt_ff + CW'(1);
            if (cnt_ff == CW'(PW - 1)) state_in = S_CMD;
            if (cnt_ff == CW'(PW - 1)) clamp_in = 1'b1;
         end
         S_DIFF: begin
            diff_in = (DW+1)'(cmd_ff) - (DW+1)'(fv_ff[ax_ff]);
            state_in = S_FILT;
         end
         S_FILT: begin
            if (fsum > (DW+2)'(SMAX)) fv_in[ax_ff] = SMAX[SW-1:0];
            else if (fsum < (DW+2)'(SMIN)) fv_in[ax_ff] = SMIN[SW-1:0];
            else fv_in[ax_ff] = fsum[SW-1:0];
            if (ax_ff == 2'd2) begin
               state_in = S_OUT;
            end else begin
               ax_in = ax_ff + 2'd1;
               state_in = S_CMD;
            end
         end
         S_OUT: begin
            if (!out_valid_ff || out_ready) begin
               ox_in = fv_ff[0];
               oy_in = fv_ff[1];
               oz_in = fv_ff[2];
               out_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // quotient reuse: after the divide the quotient sits in quo_ff and S_CMD
   // is revisited, so track whether it is fresh
   logic div_done_ff, div_done_in;
   always_comb begin
      div_done_in = div_done_ff;
      if (state_ff == S_DIV && cnt_ff == CW'(PW - 1)) div_done_in = 1'b1;
      else if (state_ff == S_CMD) div_done_in = 1'b0;
   end

   logic signed [DW-1:0] cmd_div;
   assign cmd_div = cmd_sat;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         out_valid_ff <= 1'b0;
         div_done_ff <= 1'b0;
         for (int i = 0; i < 3; i++) fv_ff[i] <= '0;
      end else begin
         state_ff <= (state_ff == S_CMD && div_done_ff) ? S_DIFF : state_in;
         out_valid_ff <= out_valid_in;
         div_done_ff <= div_done_in;
         fv_ff <= fv_in;
      end
      m_ff <= m_in;
      neg_ff <= neg_in;
      live_ff <= live_in;
      gain_ff <= gain_in;
      norm_ff <= norm_in;
      clamp_ff <= clamp_in;
      ax_ff <= ax_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      cmd_ff <= (state_ff == S_CMD && div_done_ff) ? cmd_div : cmd_in;
      diff_ff <= diff_in;
      ox_ff <= ox_in;
      oy_ff <= oy_in;
      oz_ff <= oz_in;
   end

   assign in_ready = (state_ff == S_IDLE);
   assign out_valid = out_valid_ff;
   assign out_x = ox_ff;
   assign out_y = oy_ff;
   assign out_z = oz_ff;
endmodule
`default_nettype wire

// ----- rtl/teleop_velocity_mapper_unit.sv -----
// ----------------------------------------------------------------------------
// teleop_velocity_mapper_unit: haptic offset to filtered velocity command
// Deadzone, distance-dependent gain, speed clamp and one-pole low-pass.
// ----------------------------------------------------------------------------
// req_ channel: one haptic offset item (pos_x, pos_y, pos_z), Q16 metres
// rsp_ channel: one filtered velocity item (vel_x, vel_y, vel_z) per request
// csr_ port: write-only registers, index as listed in tvm_pkg, only when idle
// front: a square per axis, SAMPLE_WIDTH + 2 root steps, gain and hand-off
// back: norm clamp check, then command, difference and filter per axis, and
//   output; each clamped axis adds a serial divide
// front and back overlap: the front takes a new item while the back is busy
//   with the last one
// reset: registers take their defaults, stored velocity clears to zero
// stalls: a result waits in the output register; the back part finishes the
//   next item and holds, then the front holds, then req_ready stays low
// ----------------------------------------------------------------------------
`default_nettype none
module teleop_velocity_mapper_unit #(
   parameter int unsigned FRAC_BITS = 16,
   parameter int unsigned SAMPLE_WIDTH = 24
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire logic signed [SAMPLE_WIDTH-1:0] req_pos_x,
   input  wire logic signed [SAMPLE_WIDTH-1:0] req_pos_y,
   input  wire logic signed [SAMPLE_WIDTH-1:0] req_pos_z,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic signed [SAMPLE_WIDTH-1:0]   rsp_vel_x,
   output logic signed [SAMPLE_WIDTH-1:0]   rsp_vel_y,
   output logic signed [SAMPLE_WIDTH-1:0]   rsp_vel_z,
   input  wire logic                        csr_write,
   input  wire logic [tvm_pkg::CsrIdxWidth-1:0]  csr_index,
   input  wire logic [tvm_pkg::CsrDataWidth-1:0] csr_data
);
   localparam int unsigned MW = SAMPLE_WIDTH + 1;

   // configuration registers
   logic [16:0] dz_ff;
   logic [15:0] ge_ff, gs_ff, al_ff;
   logic [20:0] ms_ff;
   logic ze_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dz_ff <= 17'd655;
         ge_ff <= 16'd4096;
         gs_ff <= 16'd9600;
         ms_ff <= 21'd6554;
         al_ff <= 16'd409;
         ze_ff <= 1'b1;
      end else if (csr_write) begin
         unique case (csr_index)
            tvm_pkg::REG_DEADZONE: dz_ff <= csr_data[16:0];
            tvm_pkg::REG_GAIN_EDGE: ge_ff <= csr_data[15:0];
            tvm_pkg::REG_GAIN_SLOPE: gs_ff <= csr_data[15:0];
            tvm_pkg::REG_MAX_SPEED: ms_ff <= csr_data[20:0];
            tvm_pkg::REG_ALPHA: al_ff <= csr_data[15:0];
            tvm_pkg::REG_Z_ENABLE: ze_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   // front to back: single-entry hand-off register in the front part
   logic f_valid, b_ready;
   logic [MW-1:0] f_mx, f_my, f_mz;
   logic [2:0] f_neg;
   logic f_live;
   logic [15:0] f_gain;
   logic [MW:0] f_norm;

   tvm_front #(.SW(SAMPLE_WIDTH), .FB(FRAC_BITS)) u_front (
      .clock(clock), .reset(reset),
      .in_valid(req_valid), .in_ready(req_ready),
      .in_x(req_pos_x), .in_y(req_pos_y), .in_z(req_pos_z),
      .deadzone(dz_ff), .gain_edge(ge_ff), .gain_slope(gs_ff),
      .out_valid(f_valid), .out_ready(b_ready),
      .out_mx(f_mx), .out_my(f_my), .out_mz(f_mz), .out_neg(f_neg),
      .out_live(f_live), .out_gain(f_gain), .out_norm(f_norm)
   );

   tvm_back #(.SW(SAMPLE_WIDTH)) u_back (
      .clock(clock), .reset(reset),
      .in_valid(f_valid), .in_ready(b_ready),
      .in_mx(f_mx), .in_my(f_my), .in_mz(f_mz), .in_neg(f_neg),
      .in_live(f_live), .in_gain(f_gain), .in_norm(f_norm),
      .max_speed(ms_ff), .alpha(al_ff), .z_enable(ze_ff),
      .out_valid(rsp_valid), .out_ready(rsp_ready),
      .out_x(rsp_vel_x), .out_y(rsp_vel_y), .out_z(rsp_vel_z)
   );
endmodule
`default_nettype wire

// ----- tb/sv/tb_teleop_velocity_mapper_unit.sv -----
// ----------------------------------------------------------------------------
// tb_teleop_velocity_mapper_unit: self-checking bench for the velocity mapper
// Directed table then random offsets under several register settings; every
// velocity item is compared field by field with an in-bench predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module tb_teleop_velocity_mapper_unit;

   localparam int unsigned SW = 24;
   localparam int unsigned FB = 16;
   localparam longint SMAX = (64'sd1 <<< (SW - 1)) - 1;
   localparam longint SMIN = -SMAX - 1;
   localparam longint CYCLE_LIMIT = 3000000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [SW-1:0] req_pos_x = '0, req_pos_y = '0, req_pos_z = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [SW-1:0] rsp_vel_x, rsp_vel_y, rsp_vel_z;
   logic csr_write = 1'b0;
   logic [tvm_pkg::CsrIdxWidth-1:0] csr_index = '0;
   logic [tvm_pkg::CsrDataWidth-1:0] csr_data = '0;

   teleop_velocity_mapper_unit dut (.*);

   always #5 clock = ~clock;

   typedef struct {
      logic signed [SW-1:0] vx, vy, vz;
   } vel_type;

   // predictor copy of the registers and stored velocity
   longint unsigned dz_radius, edge_gain, slope_gain, speed_cap, alpha;
   bit z_on;
   longint filt_vel [3];

   vel_type vel_q [$];
   int errors = 0;
   longint cycles = 0;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   task automatic report(input string what, input longint got, input longint want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      errors++;
   endtask

   function automatic longint clip(input longint v);
      if (v > SMAX) return SMAX;
      if (v < SMIN) return SMIN;
      return v;
   endfunction

   function automatic longint unsigned int_root(input longint unsigned x);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > x) bitv >>= 2;
      while (bitv != 0) begin
         if (x >= res + bitv) begin
            x -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   function automatic longint unsigned magn(input longint v);
      return v < 0 ? longint'(-v) : longint'(v);
   endfunction

   // mirror, deadzone, gain ramp, speed clamp, z gate, low-pass
   function automatic vel_type map_velocity(input logic signed [SW-1:0] px, py, pz);
      longint p [3], cmd [3], d;
      longint unsigned sq, n, gain, cnorm, m;
      vel_type r;
      p[0] = -longint'(px);
      p[1] = -longint'(py);
      p[2] = longint'(pz);
      cmd = '{0, 0, 0};
      sq = 0;
      for (int i = 0; i < 3; i++) sq += magn(p[i]) * magn(p[i]);
      n = int_root(sq);
      if (n > dz_radius) begin
         gain = edge_gain + ((slope_gain * (n - dz_radius)) >> (FB - 4));
         if (gain > 65535) gain = 65535;
         cnorm = (gain * n) >> 12;
         for (int i = 0; i < 3; i++) begin
            if (cnorm > speed_cap) m = (magn(p[i]) * speed_cap) / n;
            else m = (gain * magn(p[i])) >> 12;
            cmd[i] = clip(p[i] < 0 ? -longint'(m) : longint'(m));
         end
      end
      if (!z_on) cmd[2] = 0;
      for (int i = 0; i < 3; i++) begin
         d = cmd[i] - filt_vel[i];
         m = (alpha * magn(d) + 32768) >> 16;
         filt_vel[i] = clip(filt_vel[i] + (d < 0 ? -longint'(m) : longint'(m)));
      end
      r.vx = SW'(filt_vel[0]);
      r.vy = SW'(filt_vel[1]);
      r.vz = SW'(filt_vel[2]);
      return r;
   endfunction

   task automatic write_reg(input logic [tvm_pkg::CsrIdxWidth-1:0] idx,
                            input longint unsigned val);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= val[tvm_pkg::CsrDataWidth-1:0];
      @(posedge clock);
      case (idx)
         tvm_pkg::REG_DEADZONE: dz_radius = val & 64'h1FFFF;
         tvm_pkg::REG_GAIN_EDGE: edge_gain = val & 64'hFFFF;
         tvm_pkg::REG_GAIN_SLOPE: slope_gain = val & 64'hFFFF;
         tvm_pkg::REG_MAX_SPEED: speed_cap = val & 64'h1FFFFF;
         tvm_pkg::REG_ALPHA: alpha = val & 64'hFFFF;
         tvm_pkg::REG_Z_ENABLE: z_on = val[0];
         default: ;
      endcase
      csr_write <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (vel_q.size() != 0) @(posedge clock);
      // the block always answers, but leave slack before touching registers
      repeat (250) @(posedge clock);
   endtask

   // send one item; the expectation is queued at acceptance
   task automatic send_pos(input logic signed [SW-1:0] px, py, pz);
      int gap;
      gap = $urandom_range(0, 9);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_pos_x <= px;
      req_pos_y <= py;
      req_pos_z <= pz;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      vel_q.insert(vel_q.size(), map_velocity(px, py, pz));
   endtask

   // receiver: random stalls, including stretches with none
   int rsp_gap = 0;
   bit rsp_busy_mode = 1'b0;
   always @(posedge clock) begin
      vel_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (vel_q.size() == 0) begin
               report("unexpected velocity item", rsp_vel_x, 0);
            end else begin
               want = vel_q.pop_front();
               if (rsp_vel_x !== want.vx) report("vel_x", rsp_vel_x, want.vx);
               if (rsp_vel_y !== want.vy) report("vel_y", rsp_vel_y, want.vy);
               if (rsp_vel_z !== want.vz) report("vel_z", rsp_vel_z, want.vz);
            end
         end
         if ($urandom_range(0, 99) == 0) rsp_busy_mode <= ~rsp_busy_mode;
         if (rsp_gap > 0) begin
            rsp_gap <= rsp_gap - 1;
            rsp_ready <= 1'b0;
         end else if (rsp_valid && rsp_ready) begin
            rsp_gap <= rsp_busy_mode ? $urandom_range(0, 9) : 0;
            rsp_ready <= rsp_busy_mode ? 1'b0 : 1'b1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // directed rows; a zero-offset row from reset state reads off as zero
   typedef struct {
      logic signed [SW-1:0] x, y, z;
      bit known;
      logic signed [SW-1:0] ex, ey, ez;
   } row_type;

   localparam logic signed [SW-1:0] PMAX = 24'sh7FFFFF;
   localparam logic signed [SW-1:0] PMIN = 24'sh800000;

   row_type rows [] = '{
      '{24'sd0, 24'sd0, 24'sd0, 1'b1, 24'sd0, 24'sd0, 24'sd0},
      '{24'sd655, 24'sd0, 24'sd0, 1'b1, 24'sd0, 24'sd0, 24'sd0},
      '{24'sd0, -24'sd655, 24'sd0, 1'b1, 24'sd0, 24'sd0, 24'sd0},
      '{24'sd0, 24'sd0, 24'sd656, 1'b0, 24'sd0, 24'sd0, 24'sd0},
      '{24'sd3000, 24'sd0, 24'sd0, 1'b0, 24'sd0, 24'sd0, 24'sd0},
      '{PMAX, PMAX, PMAX, 1'b0, 24'sd0, 24'sd0, 24'sd0},
      '{PMIN, PMIN, PMIN, 1'b0, 24'sd0, 24'sd0, 24'sd0},
      '{PMIN, 24'sd0, 24'sd0, 1'b0, 24'sd0, 24'sd0, 24'sd0},
      '{24'sd0, PMIN, PMAX, 1'b0, 24'sd0, 24'sd0, 24'sd0},
      '{-24'sd1, -24'sd1, -24'sd1, 1'b0, 24'sd0, 24'sd0, 24'sd0},
      '{24'sd40000, -24'sd20000, 24'sd10000, 1'b0, 24'sd0, 24'sd0, 24'sd0},
      '{24'sd1000, 24'sd1000, -24'sd1000, 1'b0, 24'sd0, 24'sd0, 24'sd0}
   };

   function automatic logic signed [SW-1:0] rand_pos(input int shape);
      case (shape)
         0: return SW'($urandom());
         1: return $signed(24'($urandom_range(0, 4000))) - 24'sd2000;
         2: return $signed(24'($urandom_range(0, 400000))) - 24'sd200000;
         default: return $urandom_range(0, 1) ? PMAX : PMIN;
      endcase
   endfunction

   task automatic random_items(input int count);
      int shape;
      for (int k = 0; k < count; k++) begin
         shape = $urandom_range(0, 9) < 5 ? 2 : $urandom_range(0, 3);
         send_pos(rand_pos(shape), rand_pos(shape), rand_pos(shape));
         // sender pause until all results are in
         if (k == count / 2) begin
            req_valid <= 1'b0;
            while (vel_q.size() != 0) @(posedge clock);
         end
      end
   endtask

   initial begin
      vel_type got;
      dz_radius = 655;
      edge_gain = 4096;
      slope_gain = 9600;
      speed_cap = 6554;
      alpha = 409;
      z_on = 1'b1;
      filt_vel = '{0, 0, 0};
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset values first, then extremes so the stored velocity moves fast
      foreach (rows[i]) begin
         if (i == 3) begin
            wait_drained();
            write_reg(tvm_pkg::REG_ALPHA, 65535);
         end
         send_pos(rows[i].x, rows[i].y, rows[i].z);
         if (rows[i].known) begin
            got = vel_q[vel_q.size() - 1];
            if (got.vx !== rows[i].ex || got.vy !== rows[i].ey || got.vz !== rows[i].ez)
               report("table row", i, 0);
         end
      end
      wait_drained();

      // setting: large gain, high speed limit, z gated off
      write_reg(tvm_pkg::REG_DEADZONE, 0);
      write_reg(tvm_pkg::REG_GAIN_EDGE, 65535);
      write_reg(tvm_pkg::REG_GAIN_SLOPE, 65535);
      write_reg(tvm_pkg::REG_MAX_SPEED, 1048576);
      write_reg(tvm_pkg::REG_ALPHA, 32768);
      write_reg(tvm_pkg::REG_Z_ENABLE, 0);
      random_items(300);
      wait_drained();

      // setting: zero speed limit, deadzone of 65536
      write_reg(tvm_pkg::REG_DEADZONE, 65536);
      write_reg(tvm_pkg::REG_GAIN_EDGE, 0);
      write_reg(tvm_pkg::REG_GAIN_SLOPE, 0);
      write_reg(tvm_pkg::REG_MAX_SPEED, 0);
      write_reg(tvm_pkg::REG_ALPHA, 0);
      write_reg(tvm_pkg::REG_Z_ENABLE, 1);
      random_items(150);
      wait_drained();
      write_reg(tvm_pkg::REG_ALPHA, 65535);
      random_items(150);
      wait_drained();

      // random settings
      for (int s = 0; s < 6; s++) begin
         write_reg(tvm_pkg::REG_DEADZONE, $urandom_range(0, 65536));
         write_reg(tvm_pkg::REG_GAIN_EDGE, $urandom_range(0, 65535));
         write_reg(tvm_pkg::REG_GAIN_SLOPE, $urandom_range(0, 65535));
         write_reg(tvm_pkg::REG_MAX_SPEED, $urandom_range(0, 1048576));
         write_reg(tvm_pkg::REG_ALPHA, $urandom_range(0, 65535));
         write_reg(tvm_pkg::REG_Z_ENABLE, $urandom_range(0, 1));
         random_items(100);
         wait_drained();
      end

      if (errors == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule
`default_nettype wire

// ----- files.f -----
rtl/tvm_pkg.sv
rtl/tvm_front.sv
rtl/tvm_back.sv
rtl/teleop_velocity_mapper_unit.sv
tb/sv/tb_teleop_velocity_mapper_unit.sv
